FILE: rtl/core/usp_pkg.sv
// Shared types, constants and the blacklist table of the URL script pattern detector.
`default_nettype none
package usp_pkg;

  // Window and pattern limits
  localparam int WindowLenDefault    = 27;
  localparam int PatternCountDefault = 12;
  localparam int TableSize           = 12;
  localparam int PatMaxLen           = 27;
  localparam int PatLenW             = 5;

  // Depth of the token queue and of the result queue
  localparam int QueueDepth = 2;

  typedef logic [7:0]             byte_t;
  typedef logic [PatMaxLen*8-1:0] pat_text_t;
  typedef logic [PatLenW-1:0]     pat_len_t;

  // Per-byte token handed from the front to the back
  typedef struct packed {
    logic hit;
    logic last;
  } tok_t;

  // Patterns right aligned: the final character sits in bits [7:0]
  localparam pat_text_t PAT_TEXT [TableSize] = '{
    pat_text_t'("javascript:"),
    pat_text_t'("data:text/html"),
    pat_text_t'("data:application/javascript"),
    pat_text_t'("vbscript:"),
    pat_text_t'("<script"),
    pat_text_t'("%3cscript"),
    pat_text_t'("alert("),
    pat_text_t'("onerror="),
    pat_text_t'("onload="),
    pat_text_t'("onclick="),
    pat_text_t'("eval("),
    pat_text_t'("fromcharcode(")
  };

  localparam pat_len_t PAT_LEN [TableSize] = '{
    5'd11, 5'd14, 5'd27, 5'd9, 5'd7, 5'd9, 5'd6, 5'd8, 5'd7, 5'd8, 5'd5, 5'd13
  };

  // ASCII upper case to lower case, everything else unchanged
  function automatic byte_t fold_lower(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/usp_fifo.sv
// Small generic first-in first-out queue with registered storage.
`default_nettype none
module usp_fifo #(
  parameter int Width = 2,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/usp_front.sv
// Front end: case folding, byte window and parallel blacklist compare.
`default_nettype none
module usp_front #(
  parameter int WindowLen    = usp_pkg::WindowLenDefault,
  parameter int PatternCount = usp_pkg::PatternCountDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   char_byte_i,
  input  wire logic         is_last_i,
  output usp_pkg::tok_t     tok_o
);

  localparam int HistLen = WindowLen - 1;

  usp_pkg::byte_t hist_q [HistLen];
  usp_pkg::byte_t hist_d [HistLen];
  usp_pkg::byte_t cur;
  usp_pkg::byte_t win [usp_pkg::PatMaxLen];
  logic           hit;

  assign cur = usp_pkg::fold_lower(char_byte_i);

  // Window view: distance 0 is the current byte
  always_comb begin
    win[0] = cur;
    for (int b = 1; b < usp_pkg::PatMaxLen; b++) begin
      win[b] = hist_q[b-1];
    end
  end

  // Any active pattern ending at the current byte
  always_comb begin
    logic match;
    hit = 1'b0;
    for (int k = 0; k < PatternCount; k++) begin
      match = 1'b1;
      for (int b = 0; b < usp_pkg::PatMaxLen; b++) begin
        if (b < int'(usp_pkg::PAT_LEN[k]) &&
            win[b] != usp_pkg::PAT_TEXT[k][8*b +: 8]) begin
          match = 1'b0;
        end
      end
      if (match) begin
        hit = 1'b1;
      end
    end
  end

  assign tok_o.hit  = hit;
  assign tok_o.last = is_last_i;

  // History shift; cleared at the end of each URL
  always_comb begin
    for (int i = 0; i < HistLen; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (accept_i) begin
      if (is_last_i) begin
        for (int i = 0; i < HistLen; i++) begin
          hist_d[i] = '0;
        end
      end else begin
        hist_d[0] = cur;
        for (int i = 1; i < HistLen; i++) begin
          hist_d[i] = hist_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistLen; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < HistLen; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/usp_back.sv
// Back end: sticky hit flag and one verdict per URL.
`default_nettype none
module usp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tok_empty_i,
  input  wire usp_pkg::tok_t tok_i,
  output logic               tok_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output logic               res_data_o
);

  logic found_q, found_d;

  // Take a token unless it closes a URL and the result queue is full
  assign tok_pop_o  = !tok_empty_i && (!tok_i.last || !res_full_i);
  assign res_push_o = tok_pop_o && tok_i.last;
  assign res_data_o = found_q || tok_i.hit;

  always_comb begin
    found_d = found_q;
    if (tok_pop_o) begin
      found_d = tok_i.last ? 1'b0 : (found_q || tok_i.hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/url_script_pattern_detector.sv
// Path: a final byte is stored in the token queue, and its verdict is then stored in the result queue.
// Throughput: one byte per cycle while the token queue is not full; the front
// compares all patterns in parallel and a two-entry token queue decouples it from the verdict logic.
// Result side: two-entry queue, so input keeps flowing while a verdict waits.
// Reset: asynchronous, clears the byte window, the hit flag and both queues;
// no clearing pass, the block takes bytes right after reset.
`default_nettype none
module url_script_pattern_detector #(
  parameter int WindowLen    = usp_pkg::WindowLenDefault,
  parameter int PatternCount = usp_pkg::PatternCountDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       is_last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            suspicious_o
);

  localparam int TokW = $bits(usp_pkg::tok_t);

  usp_pkg::tok_t tok_in, tok_out;
  logic          in_xfer;
  logic          tok_empty, tok_full, tok_pop;
  logic          res_push, res_data, res_full;

  assign full    = tok_full;
  assign in_xfer = push && !tok_full;

  usp_front #(
    .WindowLen    (WindowLen),
    .PatternCount (PatternCount)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .char_byte_i (char_byte_i),
    .is_last_i   (is_last_i),
    .tok_o       (tok_in)
  );

  // Token queue between front and back
  usp_fifo #(
    .Width (TokW),
    .Depth (usp_pkg::QueueDepth)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .wdata_i (tok_in),
    .pop_i   (tok_pop),
    .rdata_o (tok_out),
    .empty_o (tok_empty),
    .full_o  (tok_full)
  );

  usp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_empty_i (tok_empty),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  // Result queue toward the consumer
  usp_fifo #(
    .Width (1),
    .Depth (usp_pkg::QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .pop_i   (pop),
    .rdata_o (suspicious_o),
    .empty_o (empty),
    .full_o  (res_full)
  );

  // A verdict is never pushed into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("verdict pushed into full result queue");

  // The back never consumes a token that is not there
  assert property (@(posedge clk_i) disable iff (!rst_ni) tok_pop |-> !tok_empty)
    else $error("token popped from empty queue");

  // A final byte with room downstream is forwarded as a verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!tok_empty && tok_out.last && !res_full) |-> res_push)
    else $error("final token stalled with room in result queue");

  // A stored token that does not close a URL is always drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!tok_empty && !tok_out.last) |-> tok_pop)
    else $error("ordinary token not drained");

endmodule
`default_nettype wire
